### design/ptw_pkg.sv
// ----------------------------------------------------------------------------
// ptw_pkg
// Shared types and constants of the four-level page table walker.
// ----------------------------------------------------------------------------
package ptw_pkg;

   localparam int TABLE_PAGES_DEFAULT = 64;

   localparam int VA_W          = 48;
   localparam int FRAME_IN_W    = 6;
   localparam int INDEX_W       = 9;
   localparam int WORD_W        = 64;
   localparam int ENTRY_FRAME_W = 51;
   localparam int ENTRY_FRAME_LSB = 12;
   localparam int LEVEL_W       = 2;
   localparam int CSR_DATA_W    = 32;
   localparam int CSR_ADDR_W    = 3;

   localparam int LARGE_BIT   = 7;
   localparam int PRESENT_BIT = 0;

   localparam logic [LEVEL_W-1:0] LEVEL_TOP  = 2'd0;
   localparam logic [LEVEL_W-1:0] LEVEL_L1   = 2'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_L2   = 2'd2;
   localparam logic [LEVEL_W-1:0] LEVEL_LEAF = 2'd3;

   localparam logic ACTION_WRITE = 1'b0;
   localparam logic ACTION_WALK  = 1'b1;

   // word address bit that selects the register
   localparam logic REG_ROOT_FRAME = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_REDUCE = 3'b010,
      ST_EVAL   = 3'b100
   } state_type;

   typedef struct packed {
      logic load_walk;
      logic load_write;
      logic mem_read;
      logic mem_write;
      logic descend;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic                reduce_done;
      logic [LEVEL_W-1:0]  level;
      logic                large_page;
      logic                present;
   } status_type;

endpackage

### design/ptw_reduce.sv
// ----------------------------------------------------------------------------
// ptw_reduce
// Frame number reduction modulo TABLE_PAGES: a mask for a power of two,
// otherwise a restoring remainder unit, four bits a cycle.
// ----------------------------------------------------------------------------
module ptw_reduce #(
   parameter int TABLE_PAGES = ptw_pkg::TABLE_PAGES_DEFAULT,
   localparam int FB = $clog2(TABLE_PAGES)
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [ptw_pkg::ENTRY_FRAME_W-1:0]  value,
   output logic                               done,
   output logic [FB-1:0]                      frame
);

   localparam bit POW2 = (TABLE_PAGES & (TABLE_PAGES - 1)) == 0;

   generate
      if (POW2) begin : g_mask
         logic [FB-1:0] frame_ff;

         always_ff @(posedge clock) begin
            if (reset) begin
               frame_ff <= '0;
            end else if (start) begin
               frame_ff <= value[FB-1:0];
            end
         end

         assign done  = 1'b1;
         assign frame = frame_ff;
      end else begin : g_div
         localparam int DIG   = 4;
         localparam int STEPS = (ptw_pkg::ENTRY_FRAME_W + DIG - 1) / DIG;
         localparam int PADW  = STEPS * DIG;
         localparam int RW    = FB + 1;
         localparam int CW    = $clog2(STEPS + 1);
         localparam logic [RW-1:0] NMOD    = RW'(TABLE_PAGES);
         localparam logic [CW-1:0] CNT_ONE = CW'(1);
         localparam logic [CW-1:0] CNT_ALL = CW'(STEPS);

         logic            busy_ff, busy_in;
         logic [CW-1:0]   cnt_ff, cnt_in;
         logic [PADW-1:0] sh_ff, sh_in;
         logic [RW-1:0]   rem_ff, rem_in;
         logic [RW-1:0]   r;

         always_comb begin
            r = rem_ff;
            for (int j = 0; j < DIG; j++) begin
               r = {r[FB-1:0], sh_ff[PADW-1-j]};
               if (r >= NMOD) begin
                  r = r - NMOD;
               end
            end
         end

         always_comb begin
            busy_in = busy_ff;
            cnt_in  = cnt_ff;
            sh_in   = sh_ff;
            rem_in  = rem_ff;
            if (start) begin
               busy_in = 1'b1;
               cnt_in  = CNT_ALL;
               sh_in   = PADW'(value);
               rem_in  = '0;
            end else if (busy_ff) begin
               rem_in  = r;
               sh_in   = sh_ff << DIG;
               cnt_in  = cnt_ff - CNT_ONE;
               busy_in = (cnt_ff != CNT_ONE);
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               busy_ff <= 1'b0;
            end else begin
               busy_ff <= busy_in;
            end
            cnt_ff <= cnt_in;
            sh_ff  <= sh_in;
            rem_ff <= rem_in;
         end

         assign done  = !busy_ff;
         assign frame = rem_ff[FB-1:0];
      end
   endgenerate

endmodule

### design/ptw_datapath.sv
// ----------------------------------------------------------------------------
// ptw_datapath
// Table memory, walk registers, root frame register and result registers.
// ----------------------------------------------------------------------------
module ptw_datapath #(
   parameter int TABLE_PAGES = ptw_pkg::TABLE_PAGES_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  ptw_pkg::cmd_type                   cmd,
   output ptw_pkg::status_type                status,
   input  logic [ptw_pkg::VA_W-1:0]           req_virtual_address,
   input  logic [ptw_pkg::FRAME_IN_W-1:0]     req_write_frame,
   input  logic [ptw_pkg::INDEX_W-1:0]        req_write_index,
   input  logic [ptw_pkg::WORD_W-1:0]         req_write_value,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [ptw_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [ptw_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [ptw_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               rsp_strobe,
   output logic                               rsp_hit,
   output logic [ptw_pkg::LEVEL_W-1:0]        rsp_level,
   output logic [ptw_pkg::LEVEL_W-1:0]        rsp_page_size_code,
   output logic [ptw_pkg::WORD_W-1:0]         rsp_entry_value
);

   localparam int FB    = $clog2(TABLE_PAGES);
   localparam int AW    = FB + ptw_pkg::INDEX_W;
   localparam int DEPTH = TABLE_PAGES * (2 ** ptw_pkg::INDEX_W);
   localparam int IW    = ptw_pkg::INDEX_W;

   logic [ptw_pkg::WORD_W-1:0] mem [DEPTH];

   logic [ptw_pkg::FRAME_IN_W-1:0]    root_ff;
   logic [4*IW-1:0]                   vidx_ff;
   logic [IW-1:0]                     widx_ff;
   logic [ptw_pkg::WORD_W-1:0]        wval_ff;
   logic [ptw_pkg::LEVEL_W-1:0]       level_ff, level_in;
   logic [ptw_pkg::WORD_W-1:0]        rdata_ff;
   logic                              strobe_ff;
   logic                              hit_ff;
   logic [ptw_pkg::LEVEL_W-1:0]       rlevel_ff;
   logic [ptw_pkg::WORD_W-1:0]        entry_ff;

   logic                              red_start;
   logic [ptw_pkg::ENTRY_FRAME_W-1:0] red_value;
   logic                              red_done;
   logic [FB-1:0]                     red_frame;
   logic [IW-1:0]                     idx_sel;
   logic [AW-1:0]                     addr;
   logic                              csr_wr;
   logic                              hit_now;

   // reduction source: root on a walk, write frame on a write, entry on descent
   always_comb begin
      red_start = cmd.load_walk | cmd.load_write | cmd.descend;
      priority if (cmd.load_walk) begin
         red_value = ptw_pkg::ENTRY_FRAME_W'(root_ff);
      end else if (cmd.load_write) begin
         red_value = ptw_pkg::ENTRY_FRAME_W'(req_write_frame);
      end else begin
         red_value = rdata_ff[ptw_pkg::ENTRY_FRAME_LSB +: ptw_pkg::ENTRY_FRAME_W];
      end
   end

   ptw_reduce #(
      .TABLE_PAGES (TABLE_PAGES)
   ) u_reduce (
      .clock (clock),
      .reset (reset),
      .start (red_start),
      .value (red_value),
      .done  (red_done),
      .frame (red_frame)
   );

   always_comb begin
      unique case (level_ff)
         ptw_pkg::LEVEL_TOP: idx_sel = vidx_ff[3*IW +: IW];
         ptw_pkg::LEVEL_L1:  idx_sel = vidx_ff[2*IW +: IW];
         ptw_pkg::LEVEL_L2:  idx_sel = vidx_ff[IW +: IW];
         default:            idx_sel = vidx_ff[0 +: IW];
      endcase
   end

   assign addr = cmd.mem_write ? {red_frame, widx_ff} : {red_frame, idx_sel};

   always_ff @(posedge clock) begin
      if (cmd.mem_write) begin
         mem[addr] <= wval_ff;
      end
      if (cmd.mem_read) begin
         rdata_ff <= mem[addr];
      end
   end

   always_comb begin
      level_in = level_ff;
      if (cmd.load_walk) begin
         level_in = ptw_pkg::LEVEL_TOP;
      end else if (cmd.descend) begin
         level_in = level_ff + ptw_pkg::LEVEL_W'(1);
      end
   end

   assign hit_now = (level_ff == ptw_pkg::LEVEL_LEAF) | rdata_ff[ptw_pkg::LARGE_BIT];

   always_ff @(posedge clock) begin
      level_ff <= level_in;
      if (cmd.load_walk) begin
         vidx_ff <= req_virtual_address[ptw_pkg::VA_W-1:ptw_pkg::ENTRY_FRAME_LSB];
      end
      if (cmd.load_write) begin
         widx_ff <= req_write_index;
         wval_ff <= req_write_value;
      end
      if (cmd.finish) begin
         hit_ff    <= hit_now;
         rlevel_ff <= level_ff;
         entry_ff  <= hit_now ? rdata_ff : '0;
      end
   end

   // register file
   assign csr_wr = psel & penable & pwrite & (paddr[2] == ptw_pkg::REG_ROOT_FRAME);

   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.finish;
         if (csr_wr) begin
            root_ff <= pwdata[ptw_pkg::FRAME_IN_W-1:0];
         end
      end
   end

   assign prdata = (paddr[2] == ptw_pkg::REG_ROOT_FRAME) ?
                   ptw_pkg::CSR_DATA_W'(root_ff) : '0;

   assign status.reduce_done = red_done;
   assign status.level       = level_ff;
   assign status.large_page  = rdata_ff[ptw_pkg::LARGE_BIT];
   assign status.present     = rdata_ff[ptw_pkg::PRESENT_BIT];

   assign rsp_strobe         = strobe_ff;
   assign rsp_hit            = hit_ff;
   assign rsp_level          = rlevel_ff;
   assign rsp_page_size_code = rlevel_ff;
   assign rsp_entry_value    = entry_ff;

endmodule

### design/ptw_ctrl.sv
// ----------------------------------------------------------------------------
// ptw_ctrl
// Walk sequencer: accepts a word, waits on frame reduction, reads or writes
// the table and decides descent or stop per level.
// ----------------------------------------------------------------------------
module ptw_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  req_action,
   output logic                  busy,
   input  ptw_pkg::status_type   status,
   output ptw_pkg::cmd_type      cmd
);

   ptw_pkg::state_type state_ff, state_in;
   logic               op_ff, op_in;
   logic               stop;

   assign stop = (status.level == ptw_pkg::LEVEL_LEAF) | status.large_page | !status.present;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      cmd      = '0;
      unique case (state_ff)
         ptw_pkg::ST_IDLE: begin
            if (start) begin
               op_in    = req_action;
               state_in = ptw_pkg::ST_REDUCE;
               if (req_action == ptw_pkg::ACTION_WALK) begin
                  cmd.load_walk = 1'b1;
               end else begin
                  cmd.load_write = 1'b1;
               end
            end
         end
         ptw_pkg::ST_REDUCE: begin
            if (status.reduce_done) begin
               if (op_ff == ptw_pkg::ACTION_WALK) begin
                  cmd.mem_read = 1'b1;
                  state_in     = ptw_pkg::ST_EVAL;
               end else begin
                  cmd.mem_write = 1'b1;
                  state_in      = ptw_pkg::ST_IDLE;
               end
            end
         end
         ptw_pkg::ST_EVAL: begin
            if (stop) begin
               cmd.finish = 1'b1;
               state_in   = ptw_pkg::ST_IDLE;
            end else begin
               cmd.descend = 1'b1;
               state_in    = ptw_pkg::ST_REDUCE;
            end
         end
         default: begin
            state_in = ptw_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptw_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      op_ff <= op_in;
   end

   assign busy = (state_ff != ptw_pkg::ST_IDLE);

endmodule

### design/four_level_page_table_walker.sv
// ----------------------------------------------------------------------------
// four_level_page_table_walker
// Four-level page table walker over a local table memory loaded by words.
//
//   channel   ports                       handshake
//   request   start, busy, req_*          taken when start && !busy
//   response  rsp_strobe, rsp_*           one cycle, no back-pressure
//   csr       psel/penable/pwrite/paddr   write on access phase, pready = 1
//
// A write word needs a frame reduction, then a table memory write. A walk
// visits one to four levels, each a frame reduction, a table memory read
// and a stop or descend decision; the response shows the cycle after the
// stop. Frame reduction never stalls when TABLE_PAGES is a power of two,
// else a restoring remainder, four bits at a time. Synchronous reset returns
// to idle, clears root_frame; table contents are undefined until written.
// ----------------------------------------------------------------------------
module four_level_page_table_walker #(
   parameter int TABLE_PAGES = ptw_pkg::TABLE_PAGES_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_action,
   input  logic [ptw_pkg::VA_W-1:0]           req_virtual_address,
   input  logic [ptw_pkg::FRAME_IN_W-1:0]     req_write_frame,
   input  logic [ptw_pkg::INDEX_W-1:0]        req_write_index,
   input  logic [ptw_pkg::WORD_W-1:0]         req_write_value,
   output logic                               rsp_strobe,
   output logic                               rsp_hit,
   output logic [ptw_pkg::LEVEL_W-1:0]        rsp_level,
   output logic [ptw_pkg::LEVEL_W-1:0]        rsp_page_size_code,
   output logic [ptw_pkg::WORD_W-1:0]         rsp_entry_value,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [ptw_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [ptw_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [ptw_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready
);

   ptw_pkg::cmd_type    cmd;
   ptw_pkg::status_type status;

   assign pready = 1'b1;

   ptw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_action),
      .busy       (busy),
      .status     (status),
      .cmd        (cmd)
   );

   ptw_datapath #(
      .TABLE_PAGES (TABLE_PAGES)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_virtual_address (req_virtual_address),
      .req_write_frame     (req_write_frame),
      .req_write_index     (req_write_index),
      .req_write_value     (req_write_value),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .rsp_strobe          (rsp_strobe),
      .rsp_hit             (rsp_hit),
      .rsp_level           (rsp_level),
      .rsp_page_size_code  (rsp_page_size_code),
      .rsp_entry_value     (rsp_entry_value)
   );

endmodule

### design/ptw_checker.sv
// ----------------------------------------------------------------------------
// ptw_checker
// Port-level checks of the page table walker, bound to the top level.
// ----------------------------------------------------------------------------
module ptw_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          rsp_strobe,
   input logic                          rsp_hit,
   input logic [ptw_pkg::LEVEL_W-1:0]   rsp_level,
   input logic [ptw_pkg::LEVEL_W-1:0]   rsp_page_size_code,
   input logic [ptw_pkg::WORD_W-1:0]    rsp_entry_value
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted word did not raise busy");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("back-to-back response strobes");

   a_size_level: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_page_size_code == rsp_level)
      else $error("page size code differs from level");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_hit |-> rsp_entry_value == '0)
      else $error("miss with non-zero entry");

   a_leaf_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_level == ptw_pkg::LEVEL_LEAF |-> rsp_hit)
      else $error("leaf level stop without hit");

endmodule

bind four_level_page_table_walker ptw_checker u_ptw_checker (.*);
